// ===== sv/spim_pkg.sv =====
// Shared types, constants and request decoding for the SPI register access master.
package spim_pkg;

	// Queue depths used as defaults by the top level
	localparam int CMD_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 4;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_BIT  = 1'b1;
	localparam logic [15:0] POLL_LIMIT_RST = 16'd1000;
	localparam logic [7:0]  BURST_BIT_RST  = 8'h40;

	// Header masks and the filler byte clocked out during a read
	localparam logic [7:0] WRITE_MASK = 8'h7F;
	localparam logic [7:0] READ_FLAG  = 8'h80;
	localparam logic [7:0] PAD_BYTE   = 8'h00;

	// Request type codes on the input port
	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_WRITE  = 3'd1;
	localparam logic [2:0] REQ_READ   = 3'd2;
	localparam logic [2:0] REQ_STROBE = 3'd3;
	localparam logic [2:0] REQ_BURST  = 3'd4;
	localparam logic [2:0] REQ_DATA   = 3'd5;

	typedef enum logic [2:0] {
		K_TICK,
		K_WRITE,
		K_READ,
		K_STROBE,
		K_BURST,
		K_DATA,
		K_BAD
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_LO,
		PH_HI,
		PH_END,
		PH_HOLD
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  address;
		logic [7:0]  data;
		logic        last;
		logic        miso;
	} cmd_t;

	typedef struct packed {
		logic        cs_level;
		logic        sck_level;
		logic        mosi_level;
		logic        busy_res;
		logic [7:0]  read_data;
		logic        read_valid;
		logic        rejected;
		logic        timed_out;
	} res_t;

	function automatic kind_t classify(input logic [2:0] req);
		kind_t k;
		begin
			unique case (req)
				REQ_TICK:   k = K_TICK;
				REQ_WRITE:  k = K_WRITE;
				REQ_READ:   k = K_READ;
				REQ_STROBE: k = K_STROBE;
				REQ_BURST:  k = K_BURST;
				REQ_DATA:   k = K_DATA;
				default:    k = K_BAD;
			endcase
			return k;
		end
	endfunction

endpackage

// ===== sv/spim_fifo.sv =====
// Small synchronous queue with a registered entry array and occupancy count.
module spim_fifo
	import spim_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = CMD_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/spim_front.sv =====
// Front end: decode each request into a command and queue it for the engine.
module spim_front
	import spim_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] req_type,
	input  logic [7:0] address,
	input  logic [7:0] data,
	input  logic       last,
	input  logic       miso,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_take
);
	cmd_t cmd_in;
	logic cmd_empty;

	always_comb begin
		cmd_in.kind    = classify(req_type);
		cmd_in.address = address;
		cmd_in.data    = data;
		cmd_in.last    = last;
		cmd_in.miso    = miso;
	end

	spim_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(cmd_in),
		.full   (full),
		.rd_en  (cmd_take),
		.rd_data(cmd),
		.empty  (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

// ===== sv/spim_back.sv =====
// Back end: pin sequencer that executes one queued command per cycle while the result queue has room.
module spim_back
	import spim_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] poll_limit,
	input  logic [7:0]  burst_bit,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_take,
	input  logic        res_room,
	output logic        res_push,
	output res_t        res
);
	phase_t      phase_q, phase_d;
	logic [2:0]  bit_pos_q, bit_pos_d;
	logic [7:0]  out_shift_q, out_shift_d;
	logic [7:0]  in_shift_q, in_shift_d;
	logic [15:0] poll_q, poll_d;
	logic [7:0]  pend_byte_q, pend_byte_d;
	logic        has_pend_q, has_pend_d;
	logic        is_read_q, is_read_d;
	logic        burst_open_q, burst_open_d;
	logic        release_q, release_d;
	logic        cs_q, cs_d;
	logic        sck_q, sck_d;
	logic        mosi_q, mosi_d;

	logic [15:0] poll_inc;
	logic [7:0]  header;
	logic [7:0]  second;
	logic        is_cmd;

	assign cmd_take = cmd_valid && res_room;
	assign res_push = cmd_take;
	assign poll_inc = poll_q + 16'd1;
	assign is_cmd   = (cmd.kind == K_WRITE) || (cmd.kind == K_READ) ||
	                  (cmd.kind == K_STROBE) || (cmd.kind == K_BURST);

	always_comb begin
		unique case (cmd.kind)
			K_WRITE: begin
				header = cmd.address & WRITE_MASK;
				second = cmd.data;
			end
			K_READ: begin
				header = cmd.address | READ_FLAG;
				second = PAD_BYTE;
			end
			K_BURST: begin
				header = cmd.address | burst_bit;
				second = PAD_BYTE;
			end
			default: begin
				header = cmd.address;
				second = PAD_BYTE;
			end
		endcase
	end

	// Next state
	always_comb begin
		phase_d      = phase_q;
		bit_pos_d    = bit_pos_q;
		out_shift_d  = out_shift_q;
		in_shift_d   = in_shift_q;
		poll_d       = poll_q;
		pend_byte_d  = pend_byte_q;
		has_pend_d   = has_pend_q;
		is_read_d    = is_read_q;
		burst_open_d = burst_open_q;
		release_d    = release_q;
		cs_d         = cs_q;
		sck_d        = sck_q;
		mosi_d       = mosi_q;
		if (cmd_take) begin
			if (is_cmd) begin
				if (phase_q == PH_IDLE) begin
					is_read_d    = (cmd.kind == K_READ);
					burst_open_d = (cmd.kind == K_BURST);
					release_d    = (cmd.kind == K_BURST) && cmd.last;
					out_shift_d  = header;
					pend_byte_d  = second;
					has_pend_d   = (cmd.kind == K_WRITE) || (cmd.kind == K_READ);
					poll_d       = '0;
					in_shift_d   = '0;
					bit_pos_d    = 3'd7;
					cs_d         = 1'b0;
					phase_d      = PH_WAIT;
				end
			end else if (cmd.kind == K_DATA) begin
				if (phase_q == PH_HOLD) begin
					out_shift_d = cmd.data;
					release_d   = cmd.last;
					in_shift_d  = '0;
					bit_pos_d   = 3'd7;
					phase_d     = PH_LO;
				end
			end else if (cmd.kind == K_TICK) begin
				unique case (phase_q)
					PH_WAIT: begin
						poll_d = poll_inc;
						if (!cmd.miso || (poll_inc >= poll_limit)) begin
							phase_d = PH_LO;
						end
					end
					PH_LO: begin
						sck_d   = 1'b0;
						mosi_d  = out_shift_q[bit_pos_q];
						phase_d = PH_HI;
					end
					PH_HI: begin
						sck_d      = 1'b1;
						in_shift_d = {in_shift_q[6:0], cmd.miso};
						if (bit_pos_q != 3'd0) begin
							bit_pos_d = bit_pos_q - 3'd1;
							phase_d   = PH_LO;
						end else if (has_pend_q) begin
							out_shift_d = pend_byte_q;
							has_pend_d  = 1'b0;
							in_shift_d  = '0;
							bit_pos_d   = 3'd7;
							phase_d     = PH_LO;
						end else if (burst_open_q && !release_q) begin
							bit_pos_d = 3'd7;
							phase_d   = PH_HOLD;
						end else begin
							bit_pos_d = 3'd7;
							phase_d   = PH_END;
						end
					end
					PH_END: begin
						sck_d        = 1'b0;
						cs_d         = 1'b1;
						is_read_d    = 1'b0;
						burst_open_d = 1'b0;
						release_d    = 1'b0;
						phase_d      = PH_IDLE;
					end
					PH_HOLD: begin
						sck_d = 1'b0;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Result outputs
	always_comb begin
		res.cs_level   = cs_d;
		res.sck_level  = sck_d;
		res.mosi_level = mosi_d;
		res.busy_res   = (phase_d != PH_IDLE);
		res.rejected   = (is_cmd && (phase_q != PH_IDLE)) ||
		                 ((cmd.kind == K_DATA) && (phase_q != PH_HOLD)) ||
		                 (cmd.kind == K_BAD);
		res.timed_out  = (cmd.kind == K_TICK) && (phase_q == PH_WAIT) && cmd.miso &&
		                 (poll_inc >= poll_limit);
		res.read_valid = (cmd.kind == K_TICK) && (phase_q == PH_END) && is_read_q;
		res.read_data  = res.read_valid ? in_shift_q : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_pos_q    <= 3'd7;
			out_shift_q  <= '0;
			in_shift_q   <= '0;
			poll_q       <= '0;
			pend_byte_q  <= '0;
			has_pend_q   <= 1'b0;
			is_read_q    <= 1'b0;
			burst_open_q <= 1'b0;
			release_q    <= 1'b0;
			cs_q         <= 1'b1;
			sck_q        <= 1'b0;
			mosi_q       <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			bit_pos_q    <= bit_pos_d;
			out_shift_q  <= out_shift_d;
			in_shift_q   <= in_shift_d;
			poll_q       <= poll_d;
			pend_byte_q  <= pend_byte_d;
			has_pend_q   <= has_pend_d;
			is_read_q    <= is_read_d;
			burst_open_q <= burst_open_d;
			release_q    <= release_d;
			cs_q         <= cs_d;
			sck_q        <= sck_d;
			mosi_q       <= mosi_d;
		end
	end

endmodule

// ===== sv/spi_register_access_master.sv =====
// SPI mode-0 register access master: top level with queues and configuration registers.
//
// Pin-level SPI mode-0 master for a radio chip register port. Each request
// is one of: tick, write register, read register, strobe, burst start or
// burst data. Every accepted request yields exactly one result that carries
// the chip select, SCK and MOSI levels after that request, a busy flag, the
// captured read byte with its valid bit, a rejected flag and a timeout flag.
// A command drops chip select and enters a ready wait that polls MISO on
// each tick until it reads low or poll_limit polls have gone by; the
// access proceeds in both cases. Each following tick is one SCK half-period,
// MSB first, with MISO sampled on the rising half. Commands arriving while an
// access is in progress, burst data outside an open burst, and unknown
// request types are rejected and change nothing. Throughput is one request
// per clock while the result queue has room: the front queue takes requests,
// and the engine retires one per cycle through a registered state update into
// the result queue, where a request's result is written when the engine takes
// the request from the request queue and waits there until it is popped.
// Either side may stall freely; full rises only when the request queue fills,
// which happens only when results are not being popped. Configuration writes
// are always ready and take effect on the next clock; write them only while idle.
module spi_register_access_master
	import spim_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int RES_DEPTH = RES_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request side
	input  logic                 push,
	output logic                 full,
	input  logic [2:0]           req_type,
	input  logic [7:0]           address,
	input  logic [7:0]           data,
	input  logic                 last,
	input  logic                 miso,
	// result side
	output logic                 empty,
	input  logic                 pop,
	output logic                 cs_level,
	output logic                 sck_level,
	output logic                 mosi_level,
	output logic                 busy_res,
	output logic [7:0]           read_data,
	output logic                 read_valid,
	output logic                 rejected,
	output logic                 timed_out,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);
	logic [15:0] poll_limit_q;
	logic [7:0]  burst_bit_q;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;
	logic res_push;
	res_t res_in;
	res_t res_out;
	logic res_full;

	// Configuration registers; no backpressure on this channel
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RST;
			burst_bit_q  <= BURST_BIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_POLL_LIMIT) begin
				poll_limit_q <= cfg_data;
			end
			if (cfg_index == CFG_BURST_BIT) begin
				burst_bit_q <= cfg_data[7:0];
			end
		end
	end

	// Front: decode and hold requests until the engine takes them
	spim_front #(
		.CMD_DEPTH(CMD_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.address  (address),
		.data     (data),
		.last     (last),
		.miso     (miso),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_take (cmd_take)
	);

	// Back: advance the pin sequencer one request per cycle while there is room
	spim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll_limit(poll_limit_q),
		.burst_bit (burst_bit_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_room  (!res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Result queue decouples the engine from the consumer
	spim_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_in),
		.full   (res_full),
		.rd_en  (pop),
		.rd_data(res_out),
		.empty  (empty)
	);

	assign cs_level   = res_out.cs_level;
	assign sck_level  = res_out.sck_level;
	assign mosi_level = res_out.mosi_level;
	assign busy_res   = res_out.busy_res;
	assign read_data  = res_out.read_data;
	assign read_valid = res_out.read_valid;
	assign rejected   = res_out.rejected;
	assign timed_out  = res_out.timed_out;

	// Engine never writes into a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written while result queue full");

	// Chip select is low exactly while an access is in progress
	a_cs_tracks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (res_in.cs_level == !res_in.busy_res))
		else $error("chip select disagrees with busy");

	// A completed read ends the access
	a_read_ends_access: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_in.read_valid) |-> !res_in.busy_res)
		else $error("read completed while still busy");

	// Timeout and read completion never come from the same request
	a_tout_excl_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !(res_in.timed_out && res_in.read_valid))
		else $error("timeout and read valid together");

endmodule

// ===== tb/spi_register_access_master_test.sv =====
// Self-checking testbench for the SPI mode-0 register access master.
`timescale 1ns / 100ps

module spi_register_access_master_test;
	import spim_pkg::*;

	// Request codes the block must refuse; the package leaves them unnamed
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] addr;
		logic [7:0] dat;
		logic       last;
		logic       miso;
	} request_t;

	// Tracks the pin-level SPI state and queues the pin levels and flags that
	// every accepted request must produce, in order.
	class pin_scoreboard;
		logic [15:0] poll_limit;
		logic [7:0]  burst_mask;
		phase_t      ph;
		logic [2:0]  bit_pos;
		logic [7:0]  out_sr;
		logic [7:0]  in_sr;
		logic [15:0] polls;
		logic [7:0]  second_byte;
		bit          second_due;
		bit          reading;
		bit          burst_on;
		bit          close_after;
		logic        cs;
		logic        sck;
		logic        mosi;
		res_t        due[$];
		int          errors;

		function new();
			poll_limit = POLL_LIMIT_RST;
			burst_mask = BURST_BIT_RST;
			ph = PH_IDLE;
			bit_pos = 3'd7;
			out_sr = '0;
			in_sr = '0;
			polls = '0;
			second_byte = '0;
			second_due = 1'b0;
			reading = 1'b0;
			burst_on = 1'b0;
			close_after = 1'b0;
			cs = 1'b1;
			sck = 1'b0;
			mosi = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == CFG_POLL_LIMIT)
				poll_limit = val;
			else if (idx == CFG_BURST_BIT)
				burst_mask = val[7:0];
		endfunction

		function void open_access(logic [7:0] header, bit pend, logic [7:0] second);
			out_sr = header;
			second_byte = second;
			second_due = pend;
			polls = '0;
			in_sr = '0;
			bit_pos = 3'd7;
			cs = 1'b0;
			ph = PH_WAIT;
		endfunction

		// Advance one SCK half-period (or the ready poll) and fill in the flags
		function void tick(logic miso, inout res_t o);
			case (ph)
				PH_WAIT: begin
					polls = polls + 16'd1;
					if (!miso) begin
						ph = PH_LO;
					end else if (polls >= poll_limit) begin
						o.timed_out = 1'b1;
						ph = PH_LO;
					end
				end
				PH_LO: begin
					sck = 1'b0;
					mosi = out_sr[bit_pos];
					ph = PH_HI;
				end
				PH_HI: begin
					sck = 1'b1;
					in_sr = {in_sr[6:0], miso};
					if (bit_pos != 3'd0) begin
						bit_pos = bit_pos - 3'd1;
						ph = PH_LO;
					end else if (second_due) begin
						out_sr = second_byte;
						second_due = 1'b0;
						in_sr = '0;
						bit_pos = 3'd7;
						ph = PH_LO;
					end else if (burst_on && !close_after) begin
						bit_pos = 3'd7;
						ph = PH_HOLD;
					end else begin
						bit_pos = 3'd7;
						ph = PH_END;
					end
				end
				PH_END: begin
					sck = 1'b0;
					cs = 1'b1;
					if (reading) begin
						o.read_valid = 1'b1;
						o.read_data = in_sr;
					end
					reading = 1'b0;
					burst_on = 1'b0;
					close_after = 1'b0;
					ph = PH_IDLE;
				end
				PH_HOLD: sck = 1'b0;
				default: ph = PH_IDLE;
			endcase
		endfunction

		// Note an accepted request; return 1 unless the block refuses or ignores it
		function bit note_request(request_t r);
			res_t o;
			bit   acted;
			o = '0;
			acted = 1'b1;
			case (r.kind)
				REQ_WRITE, REQ_READ, REQ_STROBE, REQ_BURST: begin
					if (ph != PH_IDLE) begin
						o.rejected = 1'b1;
					end else begin
						reading = (r.kind == REQ_READ);
						burst_on = (r.kind == REQ_BURST);
						close_after = burst_on ? r.last : 1'b0;
						case (r.kind)
							REQ_WRITE:  open_access(r.addr & WRITE_MASK, 1'b1, r.dat);
							REQ_READ:   open_access(r.addr | READ_FLAG, 1'b1, PAD_BYTE);
							REQ_STROBE: open_access(r.addr, 1'b0, PAD_BYTE);
							default:    open_access(r.addr | burst_mask, 1'b0, PAD_BYTE);
						endcase
					end
				end
				REQ_DATA: begin
					if (ph != PH_HOLD) begin
						o.rejected = 1'b1;
					end else begin
						out_sr = r.dat;
						close_after = r.last;
						in_sr = '0;
						bit_pos = 3'd7;
						ph = PH_LO;
					end
				end
				REQ_TICK: begin
					if (ph == PH_IDLE || ph == PH_HOLD)
						acted = 1'b0;
					tick(r.miso, o);
				end
				default: o.rejected = 1'b1;
			endcase
			if (o.rejected)
				acted = 1'b0;
			o.cs_level = cs;
			o.sck_level = sck;
			o.mosi_level = mosi;
			o.busy_res = (ph != PH_IDLE);
			due.push_back(o);
			return acted;
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_pins(res_t got);
			res_t want;
			if (due.size() == 0) begin
				$display("%0t: result with nothing expected, expected none actual %p",
					$time, got);
				errors++;
				return;
			end
			want = due.pop_front();
			cmp_field("cs_level", want.cs_level, got.cs_level);
			cmp_field("sck_level", want.sck_level, got.sck_level);
			cmp_field("mosi_level", want.mosi_level, got.mosi_level);
			cmp_field("busy_res", want.busy_res, got.busy_res);
			cmp_field("read_data", want.read_data, got.read_data);
			cmp_field("read_valid", want.read_valid, got.read_valid);
			cmp_field("rejected", want.rejected, got.rejected);
			cmp_field("timed_out", want.timed_out, got.timed_out);
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [2:0]           req_type;
	logic [7:0]           address;
	logic [7:0]           data;
	logic                 last;
	logic                 miso;
	logic                 empty;
	logic                 pop;
	logic                 cs_level;
	logic                 sck_level;
	logic                 mosi_level;
	logic                 busy_res;
	logic [7:0]           read_data;
	logic                 read_valid;
	logic                 rejected;
	logic                 timed_out;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	pin_scoreboard sb = new();

	// Cycles the result side must hold off no matter what; set by the stimulus
	int rx_hold = 0;
	// Remaining requests the sender offers back to back without a gap
	int tx_calm = 0;

	spi_register_access_master dut (
		.clk, .arst_n,
		.push, .full, .req_type, .address, .data, .last, .miso,
		.empty, .pop, .cs_level, .sck_level, .mosi_level, .busy_res,
		.read_data, .read_valid, .rejected, .timed_out,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then a long one
	function automatic int gap_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Choose the next request from where the access stands: mostly the request
	// that moves a well-formed access on, the rest refused or ignored noise.
	function automatic request_t pick_request(input int hi_pct);
		request_t r;
		int       roll;
		r.kind = REQ_TICK;
		r.addr = $urandom;
		r.dat = $urandom;
		r.last = ($urandom_range(0, 2) == 0);
		// bias MISO high only while polling, so timeouts show up
		if (sb.ph == PH_WAIT)
			r.miso = ($urandom_range(0, 99) < hi_pct);
		else
			r.miso = $urandom_range(0, 1);
		roll = $urandom_range(0, 99);
		case (sb.ph)
			PH_IDLE: begin
				if (roll < 80)
					r.kind = $urandom_range(REQ_WRITE, REQ_BURST);
				else if (roll >= 88)
					r.kind = $urandom_range(REQ_DATA, REQ_SPARE_B);
			end
			PH_HOLD: begin
				if (roll < 75)
					r.kind = REQ_DATA;
				else if (roll >= 85 && roll < 95)
					r.kind = $urandom_range(REQ_WRITE, REQ_BURST);
				else if (roll >= 95)
					r.kind = $urandom_range(REQ_SPARE_A, REQ_SPARE_B);
			end
			default: begin
				if (roll >= 92)
					r.kind = $urandom_range(REQ_WRITE, REQ_SPARE_B);
			end
		endcase
		return r;
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic offer(input request_t r, output bit acted);
		push <= 1'b1;
		req_type <= r.kind;
		address <= r.addr;
		data <= r.dat;
		last <= r.last;
		miso <= r.miso;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		acted = sb.note_request(r);
	endtask

	// Drop push for a random gap, except during a calm stretch
	task automatic pace();
		int g;
		g = 0;
		if (tx_calm > 0) begin
			tx_calm--;
		end else begin
			g = gap_cycles();
			if ($urandom_range(0, 39) == 0)
				tx_calm = $urandom_range(30, 150);
		end
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [2:0] kind, input logic [7:0] addr, input logic [7:0] dat,
			input logic lst, input logic mi);
		request_t r;
		bit       acted;
		r = '{kind: kind, addr: addr, dat: dat, last: lst, miso: mi};
		offer(r, acted);
		pace();
	endtask

	// Tick until the access is finished or parked in an open burst
	task automatic run_out();
		while (sb.ph != PH_IDLE && sb.ph != PH_HOLD)
			issue(REQ_TICK, $urandom, $urandom, $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	task automatic random_run(input int count, input int hi_pct);
		int       done;
		bit       acted;
		request_t r;
		done = 0;
		while (done < count) begin
			r = pick_request(hi_pct);
			offer(r, acted);
			if (acted)
				done++;
			pace();
		end
	endtask

	// Stop offering and wait for every outstanding request to come back
	task automatic quiesce();
		push <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Result side: check each popped result, then decide pop for the next edge
	initial begin : result_side
		int stall;
		int eager;
		stall = 0;
		eager = 0;
		pop <= 1'b0;
		@(posedge clk);
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop === 1'b1 && empty === 1'b0)
				sb.check_pins('{cs_level: cs_level, sck_level: sck_level,
					mosi_level: mosi_level, busy_res: busy_res, read_data: read_data,
					read_valid: read_valid, rejected: rejected, timed_out: timed_out});
			if (rx_hold > 0) begin
				// long hold-off: let the queues fill and full rise
				pop <= 1'b0;
				rx_hold--;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (eager > 0) begin
					eager--;
				end else begin
					stall = gap_cycles();
					if ($urandom_range(0, 49) == 0)
						eager = $urandom_range(50, 200);
				end
			end
		end
	end

	initial begin : stimulus
		logic [15:0] lim;
		logic [7:0]  msk;
		int          hi;
		push <= 1'b0;
		req_type <= REQ_TICK;
		address <= '0;
		data <= '0;
		last <= 1'b0;
		miso <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_POLL_LIMIT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		// Ticks while idle change nothing; spare codes and stray burst data bounce.
		issue(REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b1);
		issue(REQ_TICK, 8'hFF, 8'hFF, 1'b1, 1'b0);
		issue(REQ_SPARE_A, 8'h00, 8'h00, 1'b0, 1'b0);
		issue(REQ_SPARE_B, 8'hFF, 8'hFF, 1'b1, 1'b1);
		issue(REQ_DATA, 8'h00, 8'hA5, 1'b1, 1'b0);
		// Read of address zero; commands arriving mid-access are refused
		issue(REQ_READ, 8'h00, 8'h00, 1'b0, 1'b0);
		issue(REQ_WRITE, 8'hFF, 8'hFF, 1'b0, 1'b0);
		issue(REQ_BURST, 8'hFF, 8'hFF, 1'b1, 1'b1);
		issue(REQ_DATA, 8'h5A, 8'h5A, 1'b0, 1'b0);
		// One busy poll, then ready
		issue(REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b1);
		issue(REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b0);
		run_out();
		// Writes with extreme address and data
		issue(REQ_WRITE, 8'hFF, 8'h00, 1'b0, 1'b0);
		run_out();
		issue(REQ_WRITE, 8'h00, 8'hFF, 1'b1, 1'b0);
		run_out();
		issue(REQ_STROBE, 8'hFF, 8'h00, 1'b0, 1'b0);
		run_out();
		// Burst: header parks in hold, tick in hold only drops SCK,
		// a command in hold bounces, then two data bytes, the second closing
		issue(REQ_BURST, 8'h3F, 8'h00, 1'b0, 1'b0);
		run_out();
		issue(REQ_TICK, 8'h00, 8'h00, 1'b0, 1'b1);
		issue(REQ_STROBE, 8'h30, 8'h00, 1'b0, 1'b0);
		issue(REQ_DATA, 8'h00, 8'hFF, 1'b0, 1'b1);
		run_out();
		issue(REQ_DATA, 8'hFF, 8'h00, 1'b1, 1'b0);
		run_out();
		// Empty burst: closes straight after the header
		issue(REQ_BURST, 8'hC0, 8'h00, 1'b1, 1'b0);
		run_out();

		random_run(150, 50);

		// Step through register settings, extremes first; a zero limit times out
		// on the first busy poll, the top limit practically never does.
		for (int i = 0; i < 6; i++) begin
			quiesce();
			case (i)
				0: begin lim = 16'd1;     msk = 8'h00; hi = 50; end
				1: begin lim = 16'd0;     msk = 8'hFF; hi = 50; end
				2: begin lim = 16'hFFFF;  msk = 8'h80; hi = 50; end
				3: begin lim = 16'd3;     msk = 8'h40; hi = 80; end
				4: begin lim = 16'd2;     msk = $urandom; hi = 70; end
				default: begin lim = $urandom_range(1, 40); msk = $urandom; hi = 60; end
			endcase
			write_reg(CFG_POLL_LIMIT, lim);
			write_reg(CFG_BURST_BIT, {8'h00, msk});
			cfg_valid <= 1'b0;
			// hold the result side off while requests keep coming
			if (i == 3)
				rx_hold = 400;
			random_run(130, hi);
		end

		quiesce();
		repeat (12) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/spim_pkg.sv
sv/spim_fifo.sv
sv/spim_front.sv
sv/spim_back.sv
sv/spi_register_access_master.sv
tb/spi_register_access_master_test.sv
